// ----- design/lth_pkg.sv -----
// Shared types and constants for the link throughput meter.
// Used by every module of the block; depends on nothing else.
package lth_pkg;

  // Field widths.
  localparam int COUNT_W = 20;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 32;
  localparam int TOTAL_W = 64;
  localparam int HEAD_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Rates are fixed point with this many fraction bits.
  localparam int RATE_FRAC_BITS = 16;
  // Bytes to bits (x8) plus the fraction scaling.
  localparam int DERIVE_SHIFT = 3 + RATE_FRAC_BITS;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Headroom is Q8.8; small values are replaced by 1.25.
  localparam int HEADROOM_MIN     = 269;
  localparam int HEADROOM_DEFAULT = 320;
  localparam int LINK_SHIFT       = 8;
  localparam int PROD_W           = RATE_W + HEAD_W;

  localparam int WINDOW_DEFAULT = 200000;

  // Exponential average: (17*old + 3*new + 10) / 20.
  localparam int EMA_OLD  = 17;
  localparam int EMA_NEW  = 3;
  localparam int EMA_BIAS = 10;
  localparam int EMA_DEN  = 20;
  localparam int EMA_W    = RATE_W + 5;

  // The divide by 20 is a shift by two followed by a multiply with the
  // reciprocal of 5: floor(y / 5) = floor(y * EMA_RECIP / 2^EMA_RECIP_SHIFT)
  // holds for every y below 2^35. The multiply is split in two halves.
  localparam int EMA_Y_W         = EMA_W - 2;
  localparam int EMA_RECIP_W     = 36;
  localparam logic [EMA_RECIP_W-1:0] EMA_RECIP = 36'hC_CCCC_CCCD;
  localparam int EMA_RECIP_SHIFT = 38;
  localparam int EMA_SPLIT       = 18;
  localparam logic [EMA_SPLIT-1:0] EMA_RECIP_LO = EMA_RECIP[EMA_SPLIT-1:0];
  localparam logic [EMA_RECIP_W-EMA_SPLIT-1:0] EMA_RECIP_HI =
    EMA_RECIP[EMA_RECIP_W-1:EMA_SPLIT];
  localparam int EMA_PART_W      = EMA_Y_W + EMA_SPLIT;
  localparam int EMA_FULL_W      = EMA_Y_W + EMA_RECIP_W;

  // Divider produces one quotient bit per cycle.
  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CONSUMPTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [TIME_W-1:0]  timestamp;
    logic [RATE_W-1:0]  given_rate;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_bytes;
    logic [RATE_W-1:0]  rate_now;
    logic [RATE_W-1:0]  rate_average;
    logic               link_ok;
  } result_t;

  typedef struct packed {
    logic     load;
    logic     mark_win;
    logic     set_sat;
    logic     div_start;
    logic     take_rate;
    logic     commit_cur;
    logic     seed_avg;
    logic     avg_load;
    logic     avg_mul;
    logic     take_avg;
    logic     load_prod;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic derive;
    logic win_open;
    logic dt_ok;
    logic sat;
    logic div_done;
    logic rate_nz;
    logic avg_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/link_throughput_meter.sv -----
// Top level of the link throughput meter; instantiates lth_ctrl and
// lth_datapath and uses the types of lth_pkg.
//
// One result follows every item transfer. An item passes from its transfer
// through the decide, update, product and output states to the loading of its
// result register when no rate is derived and no average is blended. A rate
// derived from a closed window adds a wait on the bit-serial divider, and an
// average update adds the low and high halves of the reciprocal multiply that
// stands in for the divide by 20. The divider delivers one quotient bit a cycle
// and is the only long multi-cycle unit. A new item is taken as soon as the
// previous one has reached the result register, even while that result still
// waits to be taken. Configuration writes land at once and should be made only
// while no item is in flight.
module link_throughput_meter
  import lth_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences window handling, the rate division, the
  // average update and the link check; the datapath holds all meter state and
  // arithmetic.
  lth_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  lth_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- design/lth_div.sv -----
// Restoring divider, one quotient bit per cycle, for the throughput meter.
// Depends on lth_pkg for widths.
module lth_div
  import lth_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RATE_W-1:0] num_hi,
  input  logic [RATE_W-1:0] num_lo,
  input  logic [RATE_W-1:0] divisor,
  output logic              done,
  output logic [RATE_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W-1:0]    rem;
  logic [RATE_W-1:0]    acc;
  logic [RATE_W-1:0]    dvs;

  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;
  logic [RATE_W-1:0] rem_next;

  // The upper half of the numerator is always below the divisor, so the
  // quotient fits in one word and the remainder never outgrows it.
  always_comb begin
    trial    = {rem, acc[RATE_W-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= num_hi;
        acc  <= num_lo;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        acc <= {acc[RATE_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = acc;

endmodule

// ----- design/lth_datapath.sv -----
// Datapath of the throughput meter: configuration, meter state, the rate
// divider, the average multiplier, the link check and the result register.
// Depends on lth_pkg, lth_div.
module lth_datapath
  import lth_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  item_t                item,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  logic [RATE_W-1:0]  consumption;
  logic [HEAD_W-1:0]  headroom;
  logic [TIME_W-1:0]  window;

  logic [TOTAL_W-1:0] byte_total;
  logic [TIME_W-1:0]  win_time;
  logic [TOTAL_W-1:0] win_bytes;
  logic [RATE_W-1:0]  cur_rate;
  logic [RATE_W-1:0]  avg_rate;

  logic [COUNT_W-1:0] n_reg;
  logic [TIME_W-1:0]  now_reg;
  logic [RATE_W-1:0]  rate_reg;
  logic [PROD_W-1:0]  prod;

  logic [TIME_W-1:0]  need;
  logic [TIME_W-1:0]  dt;
  logic [TOTAL_W-1:0] db;
  logic [TOTAL_W-1:0] db_hi;
  logic [TOTAL_W-1:0] db_sh;
  logic [EMA_W-1:0]   ema_sum;
  logic [HEAD_W-1:0]  head_eff;
  logic [PROD_W-1:0]  avg_sh;
  logic               link;

  logic [EMA_Y_W-1:0]    ema_y;
  logic [EMA_PART_W-1:0] ema_part;
  logic [EMA_PART_W-1:0] ema_hi;
  logic [EMA_FULL_W-1:0] ema_full;

  logic [RATE_W-1:0]  div_hi;
  logic [RATE_W-1:0]  div_lo;
  logic [RATE_W-1:0]  div_dvs;
  logic               div_done;
  logic [RATE_W-1:0]  quotient;

  always_comb begin
    need  = (window == '0) ? TIME_W'(1) : window;
    dt    = now_reg - win_time;
    db    = byte_total - win_bytes;
    db_hi = db >> (RATE_W - DERIVE_SHIFT);
    db_sh = db << DERIVE_SHIFT;
    ema_sum = EMA_W'(EMA_OLD) * EMA_W'(avg_rate) + EMA_W'(EMA_NEW) * EMA_W'(rate_reg)
            + EMA_W'(EMA_BIAS);
    // Upper half of the reciprocal product, added to the registered lower half.
    ema_hi   = EMA_PART_W'(ema_y) * EMA_PART_W'(EMA_RECIP_HI);
    ema_full = EMA_FULL_W'(ema_part) + {ema_hi, {EMA_SPLIT{1'b0}}};
    head_eff = (headroom < HEAD_W'(HEADROOM_MIN)) ? HEAD_W'(HEADROOM_DEFAULT) : headroom;
    avg_sh   = PROD_W'(avg_rate) << LINK_SHIFT;
    link     = (consumption == '0) || (avg_sh >= prod);

    div_hi  = db_hi[RATE_W-1:0];
    div_lo  = db_sh[RATE_W-1:0];
    div_dvs = dt;

    status.derive   = (rate_reg == '0) && (n_reg != '0);
    status.win_open = (win_time != '0);
    status.dt_ok    = (dt >= need);
    status.sat      = (db_hi >= TOTAL_W'(dt));
    status.div_done = div_done;
    status.rate_nz  = (rate_reg != '0);
    status.avg_zero = (avg_rate == '0);
    status.out_free = !result_valid || result_ready;
  end

  lth_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num_hi   (div_hi),
    .num_lo   (div_lo),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quotient)
  );

  // Configuration and meter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      consumption <= '0;
      headroom    <= HEAD_W'(HEADROOM_DEFAULT);
      window      <= TIME_W'(WINDOW_DEFAULT);
      byte_total  <= '0;
      win_time    <= '0;
      win_bytes   <= '0;
      cur_rate    <= '0;
      avg_rate    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CONSUMPTION: consumption <= cfg_data[RATE_W-1:0];
          CFG_HEADROOM:    headroom    <= cfg_data[HEAD_W-1:0];
          CFG_WINDOW:      window      <= cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        byte_total <= byte_total + TOTAL_W'(item.byte_count);
      end
      if (cmd.mark_win) begin
        win_time  <= now_reg;
        win_bytes <= byte_total;
      end
      if (cmd.commit_cur) begin
        cur_rate <= rate_reg;
      end
      if (cmd.seed_avg) begin
        avg_rate <= rate_reg;
      end else if (cmd.take_avg) begin
        avg_rate <= ema_full[EMA_RECIP_SHIFT+RATE_W-1:EMA_RECIP_SHIFT];
      end
    end
  end

  // Working copy of the item, the average product and the link product.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_reg    <= item.byte_count;
      now_reg  <= item.timestamp;
      rate_reg <= item.given_rate;
    end else if (cmd.set_sat) begin
      rate_reg <= RATE_MAX;
    end else if (cmd.take_rate) begin
      rate_reg <= quotient;
    end
    if (cmd.avg_load) begin
      ema_y <= ema_sum[EMA_W-1:2];
    end
    if (cmd.avg_mul) begin
      ema_part <= EMA_PART_W'(ema_y) * EMA_PART_W'(EMA_RECIP_LO);
    end
    if (cmd.load_prod) begin
      prod <= PROD_W'(consumption) * PROD_W'(head_eff);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.total_bytes  <= byte_total;
      result.rate_now     <= cur_rate;
      result.rate_average <= avg_rate;
      result.link_ok      <= link;
    end
  end

endmodule

// ----- design/lth_ctrl.sv -----
// Sequencing state machine of the throughput meter.
// Depends on lth_pkg for the command and status structs.
module lth_ctrl
  import lth_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV_RATE,
    S_UPDATE,
    S_AVG_LO,
    S_AVG_HI,
    S_PROD,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_UPDATE;
        if (status.derive) begin
          if (!status.win_open) begin
            cmd.mark_win = 1'b1;
          end else if (status.dt_ok) begin
            cmd.mark_win = 1'b1;
            if (status.sat) begin
              cmd.set_sat = 1'b1;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV_RATE;
            end
          end
        end
      end
      S_DIV_RATE: begin
        if (status.div_done) begin
          cmd.take_rate = 1'b1;
          state_next    = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_PROD;
        if (status.rate_nz) begin
          cmd.commit_cur = 1'b1;
          if (status.avg_zero) begin
            cmd.seed_avg = 1'b1;
          end else begin
            cmd.avg_load = 1'b1;
            state_next   = S_AVG_LO;
          end
        end
      end
      S_AVG_LO: begin
        cmd.avg_mul = 1'b1;
        state_next  = S_AVG_HI;
      end
      S_AVG_HI: begin
        cmd.take_avg = 1'b1;
        state_next   = S_PROD;
      end
      S_PROD: begin
        cmd.load_prod = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/lth_checker.sv -----
// Port-level checks for the link throughput meter, bound to the top level.
// Depends on lth_pkg for the payload types.
module lth_checker
  import lth_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input result_t              result
);

  // A stalled result stays offered.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // Items are worked one at a time, so ready falls after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken while one is at work");

  // No new result is raised right after an item transfer.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !$rose(result_valid))
    else $error("result appeared too early");

  // Once any rate is known the average is nonzero.
  a_avg_seeded: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.rate_average == '0) |-> (result.rate_now == '0))
    else $error("average zero with a nonzero rate");

endmodule

bind link_throughput_meter lth_checker u_lth_checker (.*);

// ----- tb/link_throughput_meter_tb.sv -----
// Self-checking testbench for link_throughput_meter: directed rows, then random
// traffic under several register settings, with a built-in prediction of each reading.
// Depends on lth_pkg and the link_throughput_meter RTL only.
module link_throughput_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lth_pkg::*;

  // The block wraps the register index at two bits; index 3 addresses no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // The longest quiet stretch is the deliberate receiver hold-off below. Every other
  // pause (the work on one item, the longest sender gap, the longest receiver stall or
  // the settle time before a register write) is far shorter than the watchdog limit.
  localparam int HOLD_CYCLES    = 3000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  link_throughput_meter DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  // Our own copy of the meter: register values and running state, as after reset.
  logic [RATE_W-1:0]  reg_cons   = '0;
  logic [HEAD_W-1:0]  reg_head   = HEAD_W'(HEADROOM_DEFAULT);
  logic [CFG_W-1:0]   reg_window = CFG_W'(WINDOW_DEFAULT);
  logic [TOTAL_W-1:0] model_total = '0;
  logic [TIME_W-1:0]  win_open_time = '0;
  logic [TOTAL_W-1:0] win_open_bytes = '0;
  logic [RATE_W-1:0]  cur_rate = '0;
  logic [RATE_W-1:0]  avg_rate = '0;

  // Readings still owed by the block, oldest first.
  result_t pending_readings[$];

  // Directed rows: either a register setting or an item, optionally with a typed reading.
  typedef struct {
    bit                 is_setting;
    item_t              it;
    bit                 typed;
    result_t            want;
    logic [RATE_W-1:0]  cons;
    logic [HEAD_W-1:0]  head;
    logic [CFG_W-1:0]   win;
  } step_t;
  step_t directed_rows[$];

  logic [TIME_W-1:0] stim_clock = '0;
  int unsigned burst_left = 0;
  bit          hold_off_req = 1'b0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned fail_count = 0;
  int unsigned reported = 0;
  int unsigned settings_count = 0;
  int unsigned derived_count = 0;
  int unsigned saturated_count = 0;
  int unsigned link_low_count = 0;
  int unsigned holdoff_count = 0;
  int unsigned quiet_cycles = 0;

  // floor(grown * 8 * 2^frac / span), clamped to the rate width.
  function automatic logic [RATE_W-1:0] scaled_rate(input logic [TOTAL_W-1:0] grown,
                                                    input logic [TIME_W-1:0] span);
    logic [TOTAL_W+DERIVE_SHIFT-1:0] q;
    q = {grown, {DERIVE_SHIFT{1'b0}}} / span;
    return (q > RATE_MAX) ? RATE_MAX : q[RATE_W-1:0];
  endfunction

  // Advances our copy of the meter by one item and returns the reading it must produce.
  function automatic result_t predict_reading(input item_t it);
    logic [RATE_W-1:0] sample;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] need;
    logic [EMA_W:0]    blend;
    logic [HEAD_W-1:0] head_eff;
    result_t           r;
    sample = it.given_rate;
    model_total = model_total + TOTAL_W'(it.byte_count);
    // A missing rate with bytes present asks us to measure over the window.
    if (it.given_rate == '0 && it.byte_count != '0) begin
      if (win_open_time == '0) begin
        win_open_time = it.timestamp;
        win_open_bytes = model_total;
      end else begin
        dt = it.timestamp - win_open_time;
        need = (reg_window == '0) ? TIME_W'(1) : reg_window;
        if (dt >= need) begin
          sample = scaled_rate(model_total - win_open_bytes, dt);
          derived_count++;
          if (sample == RATE_MAX)
            saturated_count++;
          // The window restarts here even when the sample rounds down to zero.
          win_open_time = it.timestamp;
          win_open_bytes = model_total;
        end
      end
    end
    if (sample != '0) begin
      if (avg_rate == '0) begin
        avg_rate = sample;
      end else begin
        blend = (EMA_W+1)'(avg_rate) * EMA_OLD + (EMA_W+1)'(sample) * EMA_NEW + EMA_BIAS;
        avg_rate = RATE_W'(blend / EMA_DEN);
      end
      cur_rate = sample;
    end
    head_eff = (reg_head < HEADROOM_MIN) ? HEAD_W'(HEADROOM_DEFAULT) : reg_head;
    r.total_bytes  = model_total;
    r.rate_now     = cur_rate;
    r.rate_average = avg_rate;
    if (reg_cons == '0)
      r.link_ok = 1'b1;
    else
      r.link_ok = ({32'b0, avg_rate} << LINK_SHIFT) >= (64'(reg_cons) * 64'(head_eff));
    return r;
  endfunction

  function automatic void plan_item(input logic [COUNT_W-1:0] cnt,
                                    input logic [TIME_W-1:0] ts,
                                    input logic [RATE_W-1:0] rate);
    step_t s;
    s.is_setting = 1'b0;
    s.it = '{byte_count: cnt, timestamp: ts, given_rate: rate};
    s.typed = 1'b0;
    s.want = '0;
    directed_rows.push_back(s);
  endfunction

  function automatic void plan_checked(input logic [COUNT_W-1:0] cnt,
                                       input logic [TIME_W-1:0] ts,
                                       input logic [RATE_W-1:0] rate,
                                       input result_t want);
    step_t s;
    s.is_setting = 1'b0;
    s.it = '{byte_count: cnt, timestamp: ts, given_rate: rate};
    s.typed = 1'b1;
    s.want = want;
    directed_rows.push_back(s);
  endfunction

  function automatic void plan_setting(input logic [RATE_W-1:0] cons,
                                       input logic [HEAD_W-1:0] head,
                                       input logic [CFG_W-1:0] win);
    step_t s;
    s.is_setting = 1'b1;
    s.it = '0;
    s.typed = 1'b0;
    s.want = '0;
    s.cons = cons;
    s.head = head;
    s.win = win;
    directed_rows.push_back(s);
  endfunction

  // Rates spread over the whole Q16.16 range, with the top value and tiny ones favored.
  function automatic logic [RATE_W-1:0] rand_rate();
    int unsigned       r;
    logic [RATE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 40)
      v = $urandom;
    else if (r < 75)
      v = $urandom >> $urandom_range(4, 28);
    else if (r < 88)
      v = RATE_MAX;
    else
      v = $urandom_range(1, 64);
    return (v == '0) ? RATE_W'(1) : v;
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return COUNT_W'($urandom_range(1, 255));
    else if (r < 70)
      return COUNT_W'($urandom_range(256, 65535));
    else if (r < 85)
      return COUNT_W'($urandom_range(1, (1 << COUNT_W) - 1));
    else if (r < 93)
      return '1;
    return COUNT_W'(1);
  endfunction

  // Most items ask for a measured rate with time stepping on a scale set by the
  // window, so windows open, age and close; the rest carry a rate, no bytes,
  // a zero timestamp, or entirely random fields.
  function automatic item_t random_item();
    item_t           it;
    int unsigned     kind;
    int unsigned     r;
    longint unsigned w;
    longint unsigned delta;
    w = (reg_window == '0) ? 64'd1 : 64'(reg_window);
    r = $urandom_range(0, 9);
    if (r < 5)
      delta = 64'($urandom) % (w / 4 + 1);
    else if (r < 8)
      delta = w + 64'($urandom_range(0, 4)) - 2;
    else if (r < 9)
      delta = 64'($urandom);
    else
      delta = 0;
    stim_clock = stim_clock + TIME_W'(delta);
    it.byte_count = rand_count();
    it.timestamp = stim_clock;
    it.given_rate = '0;
    kind = $urandom_range(0, 99);
    if (kind >= 62 && kind < 77) begin
      it.given_rate = rand_rate();
      if ($urandom_range(0, 3) == 0)
        it.byte_count = '0;
    end else if (kind >= 77 && kind < 83) begin
      it.byte_count = '0;
    end else if (kind >= 83 && kind < 88) begin
      it.timestamp = '0;
    end else if (kind >= 88) begin
      it.byte_count = COUNT_W'($urandom);
      it.timestamp = $urandom;
      it.given_rate = $urandom;
    end
    return it;
  endfunction

  // Sender idle time: mostly back to back, some short gaps, a few long ones, and
  // now and then a burst of items with no gap at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 96)
      return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offers one item and waits for its transfer. Valid is lowered only when a gap
  // follows, so it never sees two assignments in one time step. The expected
  // reading is queued at the transfer edge; a typed reading takes the place of
  // the predicted one, but the prediction still runs to keep our state in step.
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = pick_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predicted = predict_reading(it);
    pending_readings.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  // Registers may only change with nothing in flight: wait for every reading,
  // then let the block settle past its worst-case latency.
  task automatic wait_until_quiet();
    item_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges, then the unused index, which
  // must change nothing. The headroom write carries junk above its 16 bits.
  task automatic configure(input logic [RATE_W-1:0] cons, input logic [HEAD_W-1:0] head,
                           input logic [CFG_W-1:0] win);
    cfg_write <= 1'b1;
    cfg_index <= CFG_CONSUMPTION;
    cfg_data  <= cons;
    @(posedge clk);
    cfg_index <= CFG_HEADROOM;
    cfg_data  <= {16'($urandom), head};
    @(posedge clk);
    cfg_index <= CFG_WINDOW;
    cfg_data  <= win;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_cons = cons;
    reg_head = head;
    reg_window = win;
    settings_count++;
  endtask

  // Receiver: alternates ready and stall spans of random length, counted here.
  // On request it holds off for a long stretch so that the block backs up and
  // stops taking items while the sender keeps offering them.
  initial begin : result_sink
    int unsigned span;
    int unsigned r;
    span = 0;
    forever begin
      @(posedge clk);
      if (span != 0) begin
        span--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ready <= 1'b0;
        span = HOLD_CYCLES;
        holdoff_count++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          result_ready <= 1'b1;
          span = $urandom_range(0, 8);
        end else if (r < 58) begin
          result_ready <= 1'b1;
          span = $urandom_range(30, 120);
        end else if (r < 92) begin
          result_ready <= 1'b0;
          span = $urandom_range(0, 4);
        end else begin
          result_ready <= 1'b0;
          span = $urandom_range(20, 90);
        end
      end
    end
  end

  // Compares every result transfer with the oldest reading still owed.
  always @(posedge clk) begin : reading_check
    result_t want;
    bit      bad;
    if (!rst && result_valid && result_ready) begin
      if (pending_readings.size() == 0) begin
        fail_count++;
        if (reported < 10) begin
          $display("Unexpected result transfer: total=%h rate=%h avg=%h ok=%b",
                   result.total_bytes, result.rate_now, result.rate_average,
                   result.link_ok);
          reported++;
        end
      end else begin
        want = pending_readings.pop_front();
        checked_count++;
        bad = (result.total_bytes !== want.total_bytes) ||
              (result.rate_now !== want.rate_now) ||
              (result.rate_average !== want.rate_average) ||
              (result.link_ok !== want.link_ok);
        if (!want.link_ok)
          link_low_count++;
        if (bad) begin
          fail_count++;
          if (reported < 10) begin
            $display("Mismatch on reading %0d:", checked_count);
            $display("  expected total=%h rate=%h avg=%h ok=%b", want.total_bytes,
                     want.rate_now, want.rate_average, want.link_ok);
            $display("  actual   total=%h rate=%h avg=%h ok=%b", result.total_bytes,
                     result.rate_now, result.rate_average, result.link_ok);
            reported++;
          end
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin : watchdog
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d readings owed",
                 WATCHDOG_LIMIT, pending_readings.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: no consumption known, so the link reads ok throughout.
    plan_checked('0, '0, '0, '{total_bytes: 64'd0, rate_now: '0, rate_average: '0,
                               link_ok: 1'b1});
    // A timestamp of zero cannot open a window.
    plan_checked(20'd100, '0, '0, '{total_bytes: 64'd100, rate_now: '0,
                                    rate_average: '0, link_ok: 1'b1});
    // This one opens the window at time 1000.
    plan_checked(20'd1000, 32'd1000, '0, '{total_bytes: 64'd1100, rate_now: '0,
                                           rate_average: '0, link_ok: 1'b1});
    // Largest count, but the window is still too young for a sample.
    plan_checked('1, 32'd1500, '0, '{total_bytes: 64'd1049675, rate_now: '0,
                                     rate_average: '0, link_ok: 1'b1});
    // Exactly the default window length has passed: the first sample seeds the average.
    plan_item(20'd10, 32'd201000, '0);
    plan_item('0, 32'd201500, '0);
    // One byte over a long window rounds down to a zero rate; the window restarts.
    plan_item(20'd1, 32'd1300000, '0);
    plan_item('0, '0, RATE_MAX);
    plan_item('1, '1, 32'd1);
    // Zero window length behaves as one tick; zero headroom falls back to 1.25.
    plan_setting(RATE_MAX, '0, '0);
    plan_item(20'd5, 32'd10, '0);
    plan_item('1, 32'd11, '0);
    plan_item('1, 32'd11, '0);
    // A sample taken at time zero leaves the window closed again.
    plan_item(20'd1, '0, '0);
    plan_item(20'd7, 32'd500, '0);
    // Widest window: only a full wrap of the timestamp is long enough.
    plan_setting(32'd1, '1, '1);
    plan_item(20'd1, 32'd499, '0);
    plan_item('0, '0, '0);
    // Headroom just under the minimum, and a window of one tick.
    plan_setting(32'h0001_0000, 16'd268, 32'd1);
    plan_item('1, 32'd2, '0);
    plan_item('0, 32'd3, 32'h0001_4000);
    plan_item(20'd3, 32'd4, 32'h0001_0D00);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_setting) begin
        wait_until_quiet();
        configure(directed_rows[i].cons, directed_rows[i].head, directed_rows[i].win);
      end else begin
        send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random traffic, one register setting per phase, extremes included.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_until_quiet();
      case (phase)
        0: configure('0, 16'd320, 32'd1000);
        1: configure(rand_rate(), 16'd269, 32'd1);
        2: configure(RATE_MAX, '1, 32'd200000);
        3: configure(rand_rate(), 16'd268, $urandom_range(1, 5000));
        4: configure(rand_rate(), '0, '0);
        5: configure(rand_rate(), 16'($urandom), '1);
        6: configure(rand_rate(), 16'($urandom), $urandom_range(1, 300000));
        default: configure($urandom, 16'($urandom_range(200, 400)), $urandom_range(1, 1000));
      endcase
      stim_clock = $urandom;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Midway through one phase the receiver stops long enough to back up the block.
        if (phase == 2 && k == PHASE_ITEMS / 2)
          hold_off_req = 1'b1;
        send_item(random_item(), 1'b0, '0);
      end
    end

    wait_until_quiet();
    $display("Ran %0d items under %0d register settings; %0d readings compared.",
             sent_count, settings_count, checked_count);
    $display("Measured %0d window rates (%0d at the ceiling), %0d link-low readings, %0d hold-off.",
             derived_count, saturated_count, link_low_count, holdoff_count);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
